/* src/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB conversion package
// Beat types and fixed-point constants shared by the conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W         = 17;
  localparam int CH_W          = 13;
  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 6;

  localparam int U_W   = HUE_W + 1;
  localparam int REM_W = 12;
  localparam int Q_W   = 6;
  localparam int SEC_W = 3;
  localparam int M_W   = 24;
  localparam int X_W   = 36;
  localparam int Y_W   = 16;
  localparam int Z_W   = 32;

  localparam logic [CH_W-1:0]  ONE        = CH_W'(1 << FRAC_BITS);
  localparam logic [REM_W-1:0] SECTOR     = REM_W'(60 << HUE_FRAC_BITS);
  localparam int               TURN       = 360 << HUE_FRAC_BITS;
  localparam logic [U_W-1:0]   HUE_OFFSET = U_W'(3 * TURN);
  localparam logic [M_W-1:0]   DEN        = M_W'((1 << FRAC_BITS) * (60 << HUE_FRAC_BITS));
  localparam logic [X_W-1:0]   HALF_DEN   = X_W'(((1 << FRAC_BITS) * (60 << HUE_FRAC_BITS)) / 2);

  localparam logic [11:0] RECIP15_A   = 12'd2185;
  localparam int          RECIP15_A_S = 15;
  localparam logic [15:0] RECIP15_B   = 16'd34953;
  localparam int          RECIP15_B_S = 19;
  localparam logic [11:0] RECIP6      = 12'd43;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic [CH_W-1:0]         saturation;
    logic [CH_W-1:0]         brightness;
    logic [CH_W-1:0]         alpha_in;
  } hsv_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha_out;
  } rgb_t;

endpackage

/* src/hsv_to_rgb_pixel_convert_top.sv */
// ----------------------------------------------------------------------------
// HSV to RGB pixel converter
// Seven-stage pipeline turning one HSVA pixel into one RGBA pixel.
// ----------------------------------------------------------------------------
// The hsv channel takes one pixel per beat and the rgb channel returns the
// converted pixel, in order, one beat per input beat.
// A beat is taken when valid is high and stall is low.
// Throughput is one pixel per cycle while rgb_stall is low, across the seven
// register stages; the hue sector, the three product terms and the divide by
// the sector size each sit in stages of their own.
// Reset clears the valid bit of every stage, so the pipeline comes up empty.
// When the receiver stalls, the last stage holds its beat and the stages
// behind it keep filling any empty slots.
// The hsv stall rises only when all seven stages hold beats and the
// receiver still stalls.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_convert_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              hsv_valid,
  output logic              hsv_stall,
  input  hsv2rgb_pkg::hsv_t hsv,
  output logic              rgb_valid,
  input  logic              rgb_stall,
  output hsv2rgb_pkg::rgb_t rgb
);

  localparam int CH_W  = hsv2rgb_pkg::CH_W;
  localparam int U_W   = hsv2rgb_pkg::U_W;
  localparam int REM_W = hsv2rgb_pkg::REM_W;
  localparam int Q_W   = hsv2rgb_pkg::Q_W;
  localparam int SEC_W = hsv2rgb_pkg::SEC_W;
  localparam int M_W   = hsv2rgb_pkg::M_W;
  localparam int X_W   = hsv2rgb_pkg::X_W;
  localparam int Y_W   = hsv2rgb_pkg::Y_W;
  localparam int Z_W   = hsv2rgb_pkg::Z_W;

  logic [7:1] vld;
  logic [8:1] en;

  always_comb begin
    en[8] = !rgb_stall;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign hsv_stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= hsv_valid;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: clamp saturation and value to one and offset the hue to a nonnegative value.
  logic [U_W-1:0]  u1;
  logic [CH_W-1:0] s1, v1, a1;
  logic [U_W-1:0]  u1_next;

  assign u1_next = {hsv.hue[hsv2rgb_pkg::HUE_W-1], hsv.hue} + hsv2rgb_pkg::HUE_OFFSET;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      u1 <= u1_next;
      s1 <= (hsv.saturation > hsv2rgb_pkg::ONE) ? hsv2rgb_pkg::ONE : hsv.saturation;
      v1 <= (hsv.brightness > hsv2rgb_pkg::ONE) ? hsv2rgb_pkg::ONE : hsv.brightness;
      a1 <= hsv.alpha_in;
    end
  end

  // Stage 2: quotient by the sector size.
  logic [21:0]     q_prod;
  logic [Q_W-1:0]  q2;
  logic [U_W-1:0]  u2;
  logic [CH_W-1:0] s2, v2, a2;

  assign q_prod = 22'(u1[U_W-1:8]) * 22'(hsv2rgb_pkg::RECIP15_A);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q2 <= q_prod[hsv2rgb_pkg::RECIP15_A_S+Q_W-1:hsv2rgb_pkg::RECIP15_A_S];
      u2 <= u1;
      s2 <= s1;
      v2 <= v1;
      a2 <= a1;
    end
  end

  // Stage 3: remainder within the sector and sector number.
  logic [U_W-1:0]   rem_full;
  logic [11:0]      six_prod;
  logic [Q_W-1:0]   sec_full;
  logic [REM_W-1:0] rem3;
  logic [SEC_W-1:0] sec3;
  logic [CH_W-1:0]  s3, v3, a3;

  assign rem_full = u2 - U_W'(q2) * U_W'(hsv2rgb_pkg::SECTOR);
  assign six_prod = 12'(q2) * hsv2rgb_pkg::RECIP6;
  assign sec_full = q2 - Q_W'(6) * Q_W'(six_prod[10:8]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rem3 <= rem_full[REM_W-1:0];
      sec3 <= sec_full[SEC_W-1:0];
      s3   <= s2;
      v3   <= v2;
      a3   <= a2;
    end
  end

  // Stage 4: the factors of p, q and t.
  logic [REM_W-1:0] k_t;
  logic [M_W-1:0]   mp4, mq4, mt4;
  logic [SEC_W-1:0] sec4;
  logic [CH_W-1:0]  v4, a4;

  assign k_t = hsv2rgb_pkg::SECTOR - rem3;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mp4  <= hsv2rgb_pkg::DEN - M_W'(hsv2rgb_pkg::SECTOR) * M_W'(s3);
      mq4  <= hsv2rgb_pkg::DEN - M_W'(rem3) * M_W'(s3);
      mt4  <= hsv2rgb_pkg::DEN - M_W'(k_t) * M_W'(s3);
      sec4 <= sec3;
      v4   <= v3;
      a4   <= a3;
    end
  end

  // Stage 5: scale by the value channel with rounding offset.
  logic [X_W-1:0]   xp5, xq5, xt5;
  logic [SEC_W-1:0] sec5;
  logic [CH_W-1:0]  v5, a5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      xp5  <= X_W'(v4) * X_W'(mp4) + hsv2rgb_pkg::HALF_DEN;
      xq5  <= X_W'(v4) * X_W'(mq4) + hsv2rgb_pkg::HALF_DEN;
      xt5  <= X_W'(v4) * X_W'(mt4) + hsv2rgb_pkg::HALF_DEN;
      sec5 <= sec4;
      v5   <= v4;
      a5   <= a4;
    end
  end

  // Stage 6: divide by the power-of-two part, multiply by the reciprocal of 15.
  logic [Z_W-1:0]   zp6, zq6, zt6;
  logic [SEC_W-1:0] sec6;
  logic [CH_W-1:0]  v6, a6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      zp6  <= Z_W'(xp5[X_W-1:X_W-Y_W]) * Z_W'(hsv2rgb_pkg::RECIP15_B);
      zq6  <= Z_W'(xq5[X_W-1:X_W-Y_W]) * Z_W'(hsv2rgb_pkg::RECIP15_B);
      zt6  <= Z_W'(xt5[X_W-1:X_W-Y_W]) * Z_W'(hsv2rgb_pkg::RECIP15_B);
      sec6 <= sec5;
      v6   <= v5;
      a6   <= a5;
    end
  end

  // Stage 7: place p, q and t by sector.
  localparam int ZS = hsv2rgb_pkg::RECIP15_B_S;

  logic [CH_W-1:0] p7, q7, t7;
  hsv2rgb_pkg::rgb_t rgb_next;
  hsv2rgb_pkg::rgb_t rgb_q;

  assign p7 = zp6[ZS+CH_W-1:ZS];
  assign q7 = zq6[ZS+CH_W-1:ZS];
  assign t7 = zt6[ZS+CH_W-1:ZS];

  always_comb begin
    rgb_next.alpha_out = a6;
    case (sec6)
      3'd0: begin
        rgb_next.red = v6; rgb_next.green = t7; rgb_next.blue = p7;
      end
      3'd1: begin
        rgb_next.red = q7; rgb_next.green = v6; rgb_next.blue = p7;
      end
      3'd2: begin
        rgb_next.red = p7; rgb_next.green = v6; rgb_next.blue = t7;
      end
      3'd3: begin
        rgb_next.red = p7; rgb_next.green = q7; rgb_next.blue = v6;
      end
      3'd4: begin
        rgb_next.red = t7; rgb_next.green = p7; rgb_next.blue = v6;
      end
      default: begin
        rgb_next.red = v6; rgb_next.green = p7; rgb_next.blue = q7;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      rgb_q <= rgb_next;
    end
  end

  assign rgb       = rgb_q;
  assign rgb_valid = vld[7];

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB pixel converter testbench
// Drives HSVA pixels into the converter and compares every RGBA pixel that
// comes back against a fixed-point prediction computed in the bench. Corner
// hues, clamped channels and all six sectors come first. Long random streams
// follow under several idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum int {
    SEC_RED_YELLOW, SEC_YELLOW_GREEN, SEC_GREEN_CYAN,
    SEC_CYAN_BLUE, SEC_BLUE_MAGENTA, SEC_MAGENTA_RED
  } hue_sector_t;

  localparam int CH_W  = hsv2rgb_pkg::CH_W;
  localparam int HUE_W = hsv2rgb_pkg::HUE_W;

  localparam longint SECTOR_UNITS = 60 << hsv2rgb_pkg::HUE_FRAC_BITS;
  localparam longint TURN_UNITS   = 360 << hsv2rgb_pkg::HUE_FRAC_BITS;
  localparam longint unsigned FULL_SCALE = 1 << hsv2rgb_pkg::FRAC_BITS;
  localparam longint unsigned BLEND_DEN  = FULL_SCALE * SECTOR_UNITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hsv_valid = 1'b0;
  logic hsv_stall;
  hsv2rgb_pkg::hsv_t hsv = '0;
  logic rgb_valid;
  logic rgb_stall = 1'b0;
  hsv2rgb_pkg::rgb_t rgb;

  hsv2rgb_pkg::rgb_t pending_rgb_q[$];
  int   tx_max_wait = 0;
  int   rx_max_wait = 0;
  int   rx_hold = 0;
  int   pixels_sent = 0;
  int   pixels_checked = 0;
  int   mismatch_cnt = 0;

  hsv_to_rgb_pixel_convert_top uut (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned blend_channel(longint unsigned v, longint unsigned s,
                                                    longint unsigned k);
    longint unsigned num;
    num = v * (BLEND_DEN - k * s);
    return (num + BLEND_DEN / 2) / BLEND_DEN;
  endfunction

  function automatic hsv2rgb_pkg::rgb_t predict_rgb(hsv2rgb_pkg::hsv_t px);
    longint h;
    longint unsigned s, v, rem, p, q, t;
    hue_sector_t sec;
    hsv2rgb_pkg::rgb_t res;
    h = longint'(px.hue) % TURN_UNITS;
    if (h < 0) h += TURN_UNITS;
    s = (px.saturation > FULL_SCALE) ? FULL_SCALE : px.saturation;
    v = (px.brightness > FULL_SCALE) ? FULL_SCALE : px.brightness;
    sec = hue_sector_t'(h / SECTOR_UNITS);
    rem = h % SECTOR_UNITS;
    p = blend_channel(v, s, SECTOR_UNITS);
    q = blend_channel(v, s, rem);
    t = blend_channel(v, s, SECTOR_UNITS - rem);
    case (sec)
      SEC_RED_YELLOW: begin
        res.red = CH_W'(v); res.green = CH_W'(t); res.blue = CH_W'(p);
      end
      SEC_YELLOW_GREEN: begin
        res.red = CH_W'(q); res.green = CH_W'(v); res.blue = CH_W'(p);
      end
      SEC_GREEN_CYAN: begin
        res.red = CH_W'(p); res.green = CH_W'(v); res.blue = CH_W'(t);
      end
      SEC_CYAN_BLUE: begin
        res.red = CH_W'(p); res.green = CH_W'(q); res.blue = CH_W'(v);
      end
      SEC_BLUE_MAGENTA: begin
        res.red = CH_W'(t); res.green = CH_W'(p); res.blue = CH_W'(v);
      end
      default: begin
        res.red = CH_W'(v); res.green = CH_W'(p); res.blue = CH_W'(q);
      end
    endcase
    res.alpha_out = px.alpha_in;
    return res;
  endfunction

  function automatic hsv2rgb_pkg::hsv_t make_pixel(int h, int s, int v, int a);
    hsv2rgb_pkg::hsv_t px;
    px.hue        = HUE_W'(h);
    px.saturation = CH_W'(s);
    px.brightness = CH_W'(v);
    px.alpha_in   = CH_W'(a);
    return px;
  endfunction

  function automatic hsv2rgb_pkg::hsv_t random_pixel();
    int sel;
    int h;
    sel = $urandom_range(0, 9);
    if (sel < 7) h = $urandom_range(0, TURN_UNITS - 1);
    else if (sel < 9) h = int'($urandom_range(0, 3 * TURN_UNITS - 1)) - TURN_UNITS;
    else h = $urandom;
    return make_pixel(h,
                      ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4096) : $urandom,
                      ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4096) : $urandom,
                      ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4096) : $urandom);
  endfunction

  // The receiver may stall at random after each beat it takes.
  always @(posedge clk) begin
    if (rst) begin
      rgb_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (rgb_valid && !rgb_stall) begin
        if (pending_rgb_q.size() == 0) begin
          $error("rgb beat arrived with no pixel pending");
          mismatch_cnt++;
        end else begin
          hsv2rgb_pkg::rgb_t want;
          want = pending_rgb_q.pop_front();
          if (rgb.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, rgb.red);
            mismatch_cnt++;
          end
          if (rgb.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, rgb.green);
            mismatch_cnt++;
          end
          if (rgb.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, rgb.blue);
            mismatch_cnt++;
          end
          if (rgb.alpha_out !== want.alpha_out) begin
            $error("alpha_out: expected %0d, got %0d", want.alpha_out, rgb.alpha_out);
            mismatch_cnt++;
          end
          pixels_checked++;
        end
        rx_hold = $urandom_range(0, rx_max_wait);
      end
      if (rx_hold > 0) begin
        rgb_stall <= 1'b1;
        rx_hold--;
      end else begin
        rgb_stall <= 1'b0;
      end
    end
  end

  task automatic send_pixel(input hsv2rgb_pkg::hsv_t px);
    int gap;
    gap = $urandom_range(0, tx_max_wait);
    if (gap > 0) begin
      hsv_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hsv_valid <= 1'b1;
    hsv <= px;
    do @(posedge clk); while (hsv_stall);
    pending_rgb_q.push_back(predict_rgb(px));
    pixels_sent++;
  endtask

  task automatic drain_pipeline();
    hsv_valid <= 1'b0;
    while (pending_rgb_q.size() != 0) @(posedge clk);
  endtask

  task automatic apply_reset();
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  endtask

  task automatic test_corner_pixels();
    hsv2rgb_pkg::hsv_t corners[$];
    tx_max_wait = 3;
    rx_max_wait = 3;
    corners = '{
      make_pixel(0, 4096, 4096, 4096),
      make_pixel(TURN_UNITS, 4096, 4096, 0),
      make_pixel(TURN_UNITS - 1, 4096, 4096, 8191),
      make_pixel(-1, 4096, 4096, 1),
      make_pixel(-TURN_UNITS, 2048, 3000, 4000),
      make_pixel(3 * TURN_UNITS - 1, 2048, 3000, 100),
      make_pixel(-65536, 8191, 8191, 8191),
      make_pixel(65535, 8191, 8191, 0),
      make_pixel(1920, 0, 4096, 2048),
      make_pixel(1920, 4096, 0, 2048),
      make_pixel(5760, 8191, 2000, 2048),
      make_pixel(9600, 3000, 8191, 2048),
      make_pixel(13440, 4096, 4096, 2048),
      make_pixel(17280, 4096, 4096, 2048),
      make_pixel(21120, 4096, 4096, 2048),
      make_pixel(SECTOR_UNITS, 4096, 4096, 2048),
      make_pixel(SECTOR_UNITS - 1, 4096, 4096, 2048),
      make_pixel(5 * SECTOR_UNITS, 4096, 4096, 2048),
      make_pixel(1, 4095, 4095, 4095),
      make_pixel(-SECTOR_UNITS / 2, 1, 1, 8190),
      make_pixel(23, 4097, 4097, 4097)
    };
    foreach (corners[i]) send_pixel(corners[i]);
    drain_pipeline();
  endtask

  task automatic run_random_stream(int n, int tx_wait, int rx_wait);
    tx_max_wait = tx_wait;
    rx_max_wait = rx_wait;
    repeat (n) send_pixel(random_pixel());
    drain_pipeline();
  endtask

  task automatic test_back_to_back();
    run_random_stream(300, 0, 0);
  endtask

  task automatic test_slow_receiver();
    run_random_stream(300, 0, 17);
  endtask

  task automatic test_slow_sender();
    run_random_stream(300, 17, 0);
  endtask

  task automatic test_both_idle();
    run_random_stream(300, 17, 17);
  endtask

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    apply_reset();
    test_corner_pixels();
    test_back_to_back();
    test_slow_receiver();
    test_slow_sender();
    test_both_idle();
    repeat (20) @(posedge clk);
    if (pending_rgb_q.size() != 0) begin
      $error("%0d pixels never came back", pending_rgb_q.size());
      mismatch_cnt++;
    end
    $display("Converted %0d pixels, %0d checked: corner and wrapped hues, clamped channels,",
             pixels_sent, pixels_checked);
    $display("all six sectors, back-to-back traffic and random idle on both channels.");
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
src/hsv2rgb_pkg.sv
src/hsv_to_rgb_pixel_convert_top.sv
tb/sv/tb_top.sv
